[rtl/core/octave_value_noise_2d_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the octave value noise core
// Shared property wrappers with clock and active-low reset.
// ----------------------------------------------------------------------------
`ifndef OCTAVE_VALUE_NOISE_2D_CORE_MACROS_SVH
`define OCTAVE_VALUE_NOISE_2D_CORE_MACROS_SVH

// Implication in the same cycle
`define OVN2D_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle
`define OVN2D_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ovn2d_pkg.sv]
// ----------------------------------------------------------------------------
// ovn2d_pkg
// Shared widths, register indexes and operation codes of the noise core.
// ----------------------------------------------------------------------------
`default_nettype none

package ovn2d_pkg;

  localparam int COORD_W    = 8;
  localparam int SEED_W     = 16;
  localparam int Q16_W      = 32;
  localparam int OCT_W      = 4;
  localparam int BIAS_W     = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // divider geometry: 48-bit dividend, 32-bit divisor
  localparam int DIV_N_W    = 48;
  localparam int DIV_D_W    = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_N_W + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS         = 1'd1;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [BIAS_W-1:0] BIAS_MIN      = 11'd51;
  localparam logic [BIAS_W-1:0] BIAS_RESET    = 11'd512;
  localparam logic [OCT_W-1:0]  OCT_RESET     = 4'd1;
  localparam logic [Q16_W-1:0]  ONE_Q16       = 32'h0001_0000;
  localparam logic [Q16_W-1:0]  Q16_MAX       = 32'hFFFF_FFFF;
  localparam logic [SEED_W-1:0] NOISE_MAX     = 16'hFFFF;

endpackage

`default_nettype wire

[rtl/core/ovn2d_seed_ram.sv]
// ----------------------------------------------------------------------------
// ovn2d_seed_ram
// Seed grid storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ovn2d_seed_ram #(
  parameter int AW = 16
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic [ovn2d_pkg::SEED_W-1:0]   wdata_i,
  input  logic                           re_i,
  input  logic [AW-1:0]                  raddr_i,
  output logic [ovn2d_pkg::SEED_W-1:0]   rdata_o
);
  import ovn2d_pkg::*;

  logic [SEED_W-1:0] mem_q [2**AW];
  logic [SEED_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/ovn2d_div.sv]
// ----------------------------------------------------------------------------
// ovn2d_div
// Restoring divider, one quotient bit per cycle; a new start aborts a running request.
// ----------------------------------------------------------------------------
`default_nettype none

module ovn2d_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ovn2d_pkg::DIV_N_W-1:0] dividend_i,
  input  logic [ovn2d_pkg::DIV_D_W-1:0] divisor_i,
  output logic                          done_o,
  output logic [ovn2d_pkg::DIV_N_W-1:0] quotient_o
);
  import ovn2d_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_D_W-1:0]   rem_q, rem_d;
  logic [DIV_N_W-1:0]   quo_q, quo_d;
  logic [DIV_D_W-1:0]   dvs_q, dvs_d;
  logic [DIV_D_W:0]     shifted;
  logic [DIV_D_W+1:0]   diff;
  logic                 ge;

  // trial subtract
  assign shifted = {rem_q, quo_q[DIV_N_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = ~diff[DIV_D_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_N_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
      quo_d = {quo_q[DIV_N_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

[rtl/core/octave_value_noise_2d_core.sv]
// ----------------------------------------------------------------------------
// octave_value_noise_2d_core
// Multi-octave 2D value noise over a square seed grid with bilinear blends.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-----------------------------
//  cfg      | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//  in       | in        | in_valid_i / in_ready_o   | op_i, x_i, y_i, seed_value_i
//  out      | out       | out_valid_o / out_ready_i | noise_o, out_x_o, out_y_o
//
//  A seed write is taken when idle. Each octave of a query makes four seed
//  reads, four products on the shared multiplier and one pass through the
//  shared 48-step divider (next weight, or the final normalize).
//  GRID_SIZE must be a power of two. The seed store has no reset.
//  The result waits in an output register; a stalled result only holds the
//  core once the next query is done. Config is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module octave_value_noise_2d_core #(
  parameter int GRID_SIZE = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ovn2d_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ovn2d_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic [ovn2d_pkg::COORD_W-1:0]    x_i,
  input  logic [ovn2d_pkg::COORD_W-1:0]    y_i,
  input  logic [ovn2d_pkg::SEED_W-1:0]     seed_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ovn2d_pkg::SEED_W-1:0]     noise_o,
  output logic [ovn2d_pkg::COORD_W-1:0]    out_x_o,
  output logic [ovn2d_pkg::COORD_W-1:0]    out_y_o
);
  import ovn2d_pkg::*;

  localparam int GL = $clog2(GRID_SIZE);
  localparam int SW = $clog2(GL + 1);
  localparam int AW = 2 * GL;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_MT   = 4'd2;
  localparam logic [3:0] S_MTW  = 4'd3;
  localparam logic [3:0] S_MB   = 4'd4;
  localparam logic [3:0] S_MBW  = 4'd5;
  localparam logic [3:0] S_MV   = 4'd6;
  localparam logic [3:0] S_MVW  = 4'd7;
  localparam logic [3:0] S_MS   = 4'd8;
  localparam logic [3:0] S_MSW  = 4'd9;
  localparam logic [3:0] S_WDIV = 4'd10;
  localparam logic [3:0] S_FDIV = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0]         state_q, state_d;
  logic [OCT_W-1:0]   oct_q, oct_d;
  logic [2:0]         rcnt_q, rcnt_d;
  logic [OCT_W-1:0]   octs_q, octs_d;
  logic [BIAS_W-1:0]  bias_q, bias_d;
  logic               out_valid_q, out_valid_d;

  logic [GL-1:0]      xg_q, yg_q;
  logic [COORD_W-1:0] xr_q, yr_q;
  logic [SEED_W-1:0]  corner_q [4];
  logic [SEED_W-1:0]  top_q, bot_q, sample_q;
  logic [Q16_W-1:0]   weight_q, wsum_q, nsum_q;
  logic signed [50:0] prod_q;
  logic [SEED_W-1:0]  noise_q;
  logic [COORD_W-1:0] out_x_q, out_y_q;

  // ---- configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    octs_d = octs_q;
    bias_d = bias_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_OCTAVE_COUNT: octs_d = cfg_data_i[OCT_W-1:0];
        REG_BIAS:         bias_d = cfg_data_i;
        default:          ;
      endcase
    end
  end

  // ---- octave geometry
  logic [OCT_W-1:0]  eff_octs;
  logic              last_oct;
  logic [SW-1:0]     shamt;
  logic [GL:0]       pitch;
  logic [GL-1:0]     mask;
  logic [GL-1:0]     x1, x2, y1, y2;
  logic [GL+15:0]    fx, fy;
  logic [15:0]       bx, by;
  logic [BIAS_W-1:0] bdiv;

  assign eff_octs = (octs_q == '0) ? OCT_W'(1) : octs_q;
  assign last_oct = ((oct_q + 1'b1) >= eff_octs) || (oct_q == OCT_W'(GL));
  assign shamt    = SW'(GL) - SW'(oct_q);
  assign pitch    = (GL + 1)'(1) << shamt;
  assign mask     = GL'(pitch - 1'b1);
  assign x1       = xg_q & ~mask;
  assign y1       = yg_q & ~mask;
  assign x2       = GL'({1'b0, x1} + pitch);
  assign y2       = GL'({1'b0, y1} + pitch);
  assign fx       = {xg_q & mask, 16'h0000} >> shamt;
  assign fy       = {yg_q & mask, 16'h0000} >> shamt;
  assign bx       = fx[15:0];
  assign by       = fy[15:0];
  assign bdiv     = (bias_q < BIAS_MIN) ? BIAS_MIN : bias_q;

  // ---- seed store
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [SEED_W-1:0] ram_rdata;
  logic [1:0]        ci;
  logic              in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign ram_we     = in_fire && (op_i == OP_WRITE);
  assign ram_waddr  = {GL'(y_i), GL'(x_i)};
  assign ci         = rcnt_q[1:0];
  assign ram_re     = (state_q == S_READ) && !rcnt_q[2];
  assign ram_raddr  = {(ci[1] ? y2 : y1), (ci[0] ? x2 : x1)};

  ovn2d_seed_ram #(
    .AW (AW)
  ) u_seed_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (seed_value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---- shared multiplier: signed 18 x unsigned 32
  logic signed [17:0] mul_a;
  logic [31:0]        mul_b;
  logic signed [50:0] prod_d;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MT: begin
        mul_a = $signed({2'b00, corner_q[1]}) - $signed({2'b00, corner_q[0]});
        mul_b = {16'h0000, bx};
      end
      S_MB: begin
        mul_a = $signed({2'b00, corner_q[3]}) - $signed({2'b00, corner_q[2]});
        mul_b = {16'h0000, bx};
      end
      S_MV: begin
        mul_a = $signed({2'b00, bot_q}) - $signed({2'b00, top_q});
        mul_b = {16'h0000, by};
      end
      S_MS: begin
        mul_a = $signed({2'b00, sample_q});
        mul_b = weight_q;
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * $signed({1'b0, mul_b});

  // ---- accumulation with saturation
  logic [Q16_W:0]   wsum_sum, nsum_sum;
  logic [Q16_W-1:0] wsum_d, nsum_d;

  assign wsum_sum = {1'b0, wsum_q} + {1'b0, weight_q};
  assign nsum_sum = {1'b0, nsum_q} + {1'b0, prod_q[47:16]};
  assign wsum_d   = wsum_sum[Q16_W] ? Q16_MAX : wsum_sum[Q16_W-1:0];
  assign nsum_d   = nsum_sum[Q16_W] ? Q16_MAX : nsum_sum[Q16_W-1:0];

  // ---- shared divider
  logic               div_start, div_done;
  logic [DIV_N_W-1:0] div_dividend, div_quo;
  logic [DIV_D_W-1:0] div_divisor;

  assign div_start    = (state_q == S_MSW);
  assign div_dividend = last_oct ? {nsum_d, 16'h0000} : {8'h00, weight_q, 8'h00};
  assign div_divisor  = last_oct ? wsum_d : {{(DIV_D_W - BIAS_W){1'b0}}, bdiv};

  ovn2d_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  logic [Q16_W-1:0]  weight_next;
  logic [SEED_W-1:0] noise_next;

  assign weight_next = (div_quo[DIV_N_W-1:Q16_W] != '0) ? Q16_MAX : div_quo[Q16_W-1:0];
  assign noise_next  = (div_quo[DIV_N_W-1:SEED_W] != '0) ? NOISE_MAX : div_quo[SEED_W-1:0];

  // ---- sequencer
  always_comb begin
    state_d     = state_q;
    oct_d       = oct_q;
    rcnt_d      = rcnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_fire && (op_i == OP_QUERY)) begin
          oct_d   = '0;
          rcnt_d  = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        rcnt_d = rcnt_q + 1'b1;
        if (rcnt_q[2]) begin
          state_d = S_MT;
        end
      end
      S_MT:  state_d = S_MTW;
      S_MTW: state_d = S_MB;
      S_MB:  state_d = S_MBW;
      S_MBW: state_d = S_MV;
      S_MV:  state_d = S_MVW;
      S_MVW: state_d = S_MS;
      S_MS:  state_d = S_MSW;
      S_MSW: state_d = last_oct ? S_FDIV : S_WDIV;
      S_WDIV: begin
        if (div_done) begin
          oct_d   = oct_q + 1'b1;
          rcnt_d  = '0;
          state_d = S_READ;
        end
      end
      S_FDIV: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      oct_q       <= '0;
      rcnt_q      <= '0;
      octs_q      <= OCT_RESET;
      bias_q      <= BIAS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oct_q       <= oct_d;
      rcnt_q      <= rcnt_d;
      octs_q      <= octs_d;
      bias_q      <= bias_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---- datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (in_fire && (op_i == OP_QUERY)) begin
      xg_q     <= GL'(x_i);
      yg_q     <= GL'(y_i);
      xr_q     <= x_i;
      yr_q     <= y_i;
      weight_q <= ONE_Q16;
      wsum_q   <= '0;
      nsum_q   <= '0;
    end
    if ((state_q == S_READ) && (rcnt_q != 3'd0)) begin
      corner_q[2'(rcnt_q - 1'b1)] <= ram_rdata;
    end
    if (state_q == S_MTW) begin
      top_q <= corner_q[0] + prod_q[31:16];
    end
    if (state_q == S_MBW) begin
      bot_q <= corner_q[2] + prod_q[31:16];
    end
    if (state_q == S_MVW) begin
      sample_q <= top_q + prod_q[31:16];
    end
    if (state_q == S_MSW) begin
      wsum_q <= wsum_d;
      nsum_q <= nsum_d;
    end
    if ((state_q == S_WDIV) && div_done) begin
      weight_q <= weight_next;
    end
    // quotient holds in the divider until the result slot frees up
    if ((state_q == S_DONE) && (!out_valid_q || out_ready_i)) begin
      noise_q <= noise_next;
      out_x_q <= xr_q;
      out_y_q <= yr_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign noise_o     = noise_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;

endmodule

`default_nettype wire

[rtl/core/ovn2d_chk.sv]
// ----------------------------------------------------------------------------
// ovn2d_chk
// Port-level checks of the noise core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "octave_value_noise_2d_core_macros.svh"

module ovn2d_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          op_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [ovn2d_pkg::SEED_W-1:0]  noise_o,
  input wire logic [ovn2d_pkg::COORD_W-1:0] out_x_o,
  input wire logic [ovn2d_pkg::COORD_W-1:0] out_y_o
);
  import ovn2d_pkg::*;

  // result request holds until taken
  `OVN2D_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")
  `OVN2D_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(noise_o) && $stable(out_x_o) && $stable(out_y_o), "result payload changed while stalled")
  // a query keeps the core busy for at least the next cycle
  `OVN2D_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, in_valid_i && in_ready_o && (op_i == OP_QUERY), !in_ready_o, "ready right after a query")
  // a seed write never produces a result
  `OVN2D_ASSERT_NEXT(a_write_silent, clk_i, rst_ni, in_valid_i && in_ready_o && (op_i == OP_WRITE) && !out_valid_o, !out_valid_o, "result after a seed write")

endmodule

bind octave_value_noise_2d_core ovn2d_chk u_ovn2d_chk (.*);

`default_nettype wire
